### rtl/quadratic_root_solver_macros.svh
// shared assertion macros for the quadratic root solver checker
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define QRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/qrs_pkg.sv
package qrs_pkg;

  // coefficient width, fixed by the item format
  localparam int unsigned COEF_BITS = 16;
  // default number of fraction bits of the roots
  localparam int unsigned FRAC_BITS_DEF = 16;
  // width of each root field
  localparam int unsigned ROOT_BITS = 40;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coef_a;
    logic signed [COEF_BITS-1:0] coef_b;
    logic signed [COEF_BITS-1:0] coef_c;
  } qrs_in_t;

  typedef struct packed {
    logic signed [ROOT_BITS-1:0] first_real;
    logic signed [ROOT_BITS-1:0] first_imag;
    logic signed [ROOT_BITS-1:0] second_real;
    logic signed [ROOT_BITS-1:0] second_imag;
    logic                        roots_complex;
    logic                        lead_zero_error;
  } qrs_out_t;

endpackage

### rtl/qrs_sqrt.sv
module qrs_sqrt #(
  parameter int unsigned RAD_W  = 66,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RAD_W-1:0]    rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [RAD_W/2-1:0]  root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned SW  = RAD_W / 2;
  localparam int unsigned RMW = SW + 1;

  logic [RAD_W-1:0]  rad_q  [SW-1];
  logic [RMW-1:0]    rem_q  [SW-1];
  logic [SW-1:0]     root_q [SW];
  logic [SIDE_W-1:0] side_q [SW];
  logic              vld_q  [SW];

  // one root bit per stage, restoring
  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RAD_W-1:0]  rad_p;
    logic [RMW-1:0]    rem_p;
    logic [SW-1:0]     root_p;
    logic              vld_p;
    logic [SIDE_W-1:0] side_p;
    logic [RMW+1:0]    rem_t;
    logic [RMW+1:0]    trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rad_p  = rad_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign vld_p  = valid_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign vld_p  = vld_q[k-1];
      assign side_p = side_q[k-1];
    end

    assign rem_t = {rem_p, rad_p[RAD_W-1 -: 2]};
    assign trial = (RMW+2)'({root_p, 2'b01});
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_p[SW-2:0], ge};
        side_q[k] <= side_p;
      end
    end

    if (k < SW - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rad_q[k] <= rad_p << 2;
          rem_q[k] <= ge ? RMW'(rem_t - trial) : RMW'(rem_t);
        end
      end
    end
  end

  assign valid_o = vld_q[SW-1];
  assign root_o  = root_q[SW-1];
  assign side_o  = side_q[SW-1];

endmodule

### rtl/qrs_div.sv
module qrs_div #(
  parameter int unsigned NUM_W  = 34,
  parameter int unsigned DIV_W  = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_x_i,
  input  logic [NUM_W-1:0]  num_y_i,
  input  logic [DIV_W-1:0]  div_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [NUM_W-1:0]  quo_x_o,
  output logic [NUM_W-1:0]  quo_y_o,
  output logic [SIDE_W-1:0] side_o
);

  // dividend bits shift out the top while quotient bits shift in below
  logic [NUM_W-1:0]  dqx_q  [NUM_W];
  logic [NUM_W-1:0]  dqy_q  [NUM_W];
  logic [DIV_W-1:0]  remx_q [NUM_W-1];
  logic [DIV_W-1:0]  remy_q [NUM_W-1];
  logic [DIV_W-1:0]  div_q  [NUM_W-1];
  logic [SIDE_W-1:0] side_q [NUM_W];
  logic              vld_q  [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic [NUM_W-1:0]  dqx_p;
    logic [NUM_W-1:0]  dqy_p;
    logic [DIV_W-1:0]  remx_p;
    logic [DIV_W-1:0]  remy_p;
    logic [DIV_W-1:0]  div_p;
    logic [SIDE_W-1:0] side_p;
    logic              vld_p;
    logic [DIV_W:0]    remx_t;
    logic [DIV_W:0]    remy_t;
    logic [DIV_W:0]    dext;
    logic              gex;
    logic              gey;

    if (k == 0) begin : g_first
      assign dqx_p  = num_x_i;
      assign dqy_p  = num_y_i;
      assign remx_p = '0;
      assign remy_p = '0;
      assign div_p  = div_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign dqx_p  = dqx_q[k-1];
      assign dqy_p  = dqy_q[k-1];
      assign remx_p = remx_q[k-1];
      assign remy_p = remy_q[k-1];
      assign div_p  = div_q[k-1];
      assign side_p = side_q[k-1];
      assign vld_p  = vld_q[k-1];
    end

    assign dext   = {1'b0, div_p};
    assign remx_t = {remx_p, dqx_p[NUM_W-1]};
    assign remy_t = {remy_p, dqy_p[NUM_W-1]};
    assign gex    = (remx_t >= dext);
    assign gey    = (remy_t >= dext);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dqx_q[k]  <= {dqx_p[NUM_W-2:0], gex};
        dqy_q[k]  <= {dqy_p[NUM_W-2:0], gey};
        side_q[k] <= side_p;
      end
    end

    if (k < NUM_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          remx_q[k] <= gex ? DIV_W'(remx_t - dext) : DIV_W'(remx_t);
          remy_q[k] <= gey ? DIV_W'(remy_t - dext) : DIV_W'(remy_t);
          div_q[k]  <= div_p;
        end
      end
    end
  end

  assign valid_o = vld_q[NUM_W-1];
  assign quo_x_o = dqx_q[NUM_W-1];
  assign quo_y_o = dqy_q[NUM_W-1];
  assign side_o  = side_q[NUM_W-1];

endmodule

### rtl/quadratic_root_solver.sv
// quadratic root solver: both roots of a*x^2 + b*x + c as complex fixed point
//
// input channel (in_valid_i / in_ready_o / in_item_i) takes one item of three
// signed coefficients; output channel (out_valid_o / out_ready_i / out_item_o)
// gives one item of four 40-bit roots with FRAC_BITS fraction bits, plus the
// complex-pair flag and the lead-zero flag (a == 0, every other field zero)
//
// throughput: one item per cycle, sustained, as long as the receiver keeps up
// pipeline: a bit-per-stage square root with SW stages (half the radicand width,
// 33 at 16 fraction bits) and a bit-per-stage divider with NW stages (34 at 16
// fraction bits), plus six single registers: products, discriminant, numerators,
// magnitudes, signed quotients and the output register
//
// reset clears every stage valid bit; the pipeline comes up empty and ready
// when the output item is not taken, the whole pipeline holds in place and
// in_ready_o drops; nothing is dropped or repeated, and in_ready_o is high
// whenever the output register is empty or being taken in this cycle
module quadratic_root_solver
  import qrs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  qrs_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output qrs_out_t out_item_o
);

  localparam int unsigned CB      = COEF_BITS;
  localparam int unsigned PW      = 2 * CB;          // product width
  localparam int unsigned DW      = 2 * CB + 2;      // discriminant width, signed
  localparam int unsigned MW      = 2 * CB + 1;      // discriminant magnitude width
  localparam int unsigned RAD_RAW = MW + 2 * FRAC_BITS;
  localparam int unsigned RW      = RAD_RAW + (RAD_RAW % 2);
  localparam int unsigned SW      = RW / 2;          // root width
  localparam int unsigned NBW     = CB + FRAC_BITS + 1;
  localparam int unsigned NW      = ((CB + FRAC_BITS > SW) ? CB + FRAC_BITS : SW) + 1;
  localparam int unsigned NSW     = NW + 1;          // signed numerator width
  localparam int unsigned DVW     = CB + 1;          // denominator width
  localparam int unsigned EXT_W   = (NSW > ROOT_BITS) ? NSW : ROOT_BITS;
  localparam int unsigned SQ_SIDE = NBW + DVW + 2;
  localparam int unsigned DV_SIDE = 4;

  // global advance: everything moves unless the output item is stuck
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // stage 1: the two products
  logic                   s1_v_q;
  logic signed [PW-1:0]   s1_bb_q;
  logic signed [PW-1:0]   s1_ac_q;
  logic signed [CB-1:0]   s1_a_q;
  logic signed [CB-1:0]   s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_bb_q <= PW'(in_item_i.coef_b * in_item_i.coef_b);
      s1_ac_q <= PW'(in_item_i.coef_a * in_item_i.coef_c);
      s1_a_q  <= in_item_i.coef_a;
      s1_b_q  <= in_item_i.coef_b;
    end
  end

  // stage 2: discriminant sign and magnitude, -b scaled, denominator 2a
  logic signed [DW-1:0]  dpos;
  logic signed [DW-1:0]  dneg;
  logic signed [DW-1:0]  ac4;
  logic                  s2_v_q;
  logic [MW-1:0]         s2_mag_q;
  logic                  s2_cplx_q;
  logic                  s2_err_q;
  logic signed [NBW-1:0] s2_nb_q;
  logic signed [DVW-1:0] s2_den_q;

  assign ac4  = DW'(s1_ac_q) <<< 2;
  assign dpos = DW'(s1_bb_q) - ac4;
  assign dneg = ac4 - DW'(s1_bb_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_cplx_q <= dpos[DW-1];
      s2_mag_q  <= dpos[DW-1] ? MW'(dneg) : MW'(dpos);
      s2_nb_q   <= -(NBW'(s1_b_q) <<< FRAC_BITS);
      s2_den_q  <= DVW'(s1_a_q) <<< 1;
      s2_err_q  <= (s1_a_q == '0);
    end
  end

  // square root of |delta| scaled by 2^(2*FRAC_BITS)
  logic [RW-1:0]         rad;
  logic                  sq_v;
  logic [SW-1:0]         sq_root;
  logic [SQ_SIDE-1:0]    sq_side;
  logic signed [NBW-1:0] sq_nb;
  logic signed [DVW-1:0] sq_den;
  logic                  sq_cplx;
  logic                  sq_err;

  assign rad = RW'(s2_mag_q) << (2 * FRAC_BITS);

  qrs_sqrt #(
    .RAD_W  (RW),
    .SIDE_W (SQ_SIDE)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .rad_i   (rad),
    .side_i  ({s2_nb_q, s2_den_q, s2_cplx_q, s2_err_q}),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign {sq_nb, sq_den, sq_cplx, sq_err} = sq_side;

  // stage 3: numerators; real pair (-b+s, -b-s) or complex (-b, s)
  logic signed [NSW-1:0] nb_ext;
  logic signed [NSW-1:0] s_ext;
  logic                  s3_v_q;
  logic signed [NSW-1:0] s3_x_q;
  logic signed [NSW-1:0] s3_y_q;
  logic signed [DVW-1:0] s3_den_q;
  logic                  s3_cplx_q;
  logic                  s3_err_q;

  assign nb_ext = NSW'(sq_nb);
  assign s_ext  = NSW'($signed({1'b0, sq_root}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= sq_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_x_q    <= sq_cplx ? nb_ext : nb_ext + s_ext;
      s3_y_q    <= sq_cplx ? s_ext : nb_ext - s_ext;
      s3_den_q  <= sq_den;
      s3_cplx_q <= sq_cplx;
      s3_err_q  <= sq_err;
    end
  end

  // stage 4: magnitudes and quotient signs for truncation toward zero
  logic                  s4_v_q;
  logic [NW-1:0]         s4_mx_q;
  logic [NW-1:0]         s4_my_q;
  logic [DVW-1:0]        s4_md_q;
  logic                  s4_sx_q;
  logic                  s4_sy_q;
  logic                  s4_cplx_q;
  logic                  s4_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_mx_q   <= s3_x_q[NSW-1] ? NW'(-s3_x_q) : NW'(s3_x_q);
      s4_my_q   <= s3_y_q[NSW-1] ? NW'(-s3_y_q) : NW'(s3_y_q);
      s4_md_q   <= s3_den_q[DVW-1] ? DVW'(-s3_den_q) : DVW'(s3_den_q);
      s4_sx_q   <= s3_x_q[NSW-1] ^ s3_den_q[DVW-1];
      s4_sy_q   <= s3_y_q[NSW-1] ^ s3_den_q[DVW-1];
      s4_cplx_q <= s3_cplx_q;
      s4_err_q  <= s3_err_q;
    end
  end

  // both quotients share one divisor pipeline
  logic                  dv_v;
  logic [NW-1:0]         dv_qx;
  logic [NW-1:0]         dv_qy;
  logic [DV_SIDE-1:0]    dv_side;
  logic                  dv_sx;
  logic                  dv_sy;
  logic                  dv_cplx;
  logic                  dv_err;

  qrs_div #(
    .NUM_W  (NW),
    .DIV_W  (DVW),
    .SIDE_W (DV_SIDE)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .num_x_i (s4_mx_q),
    .num_y_i (s4_my_q),
    .div_i   (s4_md_q),
    .side_i  ({s4_sx_q, s4_sy_q, s4_cplx_q, s4_err_q}),
    .valid_o (dv_v),
    .quo_x_o (dv_qx),
    .quo_y_o (dv_qy),
    .side_o  (dv_side)
  );

  assign {dv_sx, dv_sy, dv_cplx, dv_err} = dv_side;

  // stage 5: signed quotients
  logic                    s5_v_q;
  logic signed [EXT_W-1:0] s5_rx_q;
  logic signed [EXT_W-1:0] s5_ry_q;
  logic                    s5_cplx_q;
  logic                    s5_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_rx_q   <= dv_sx ? -$signed(EXT_W'(dv_qx)) : $signed(EXT_W'(dv_qx));
      s5_ry_q   <= dv_sy ? -$signed(EXT_W'(dv_qy)) : $signed(EXT_W'(dv_qy));
      s5_cplx_q <= dv_cplx;
      s5_err_q  <= dv_err;
    end
  end

  // output register: root assignment and lead-zero override
  logic signed [ROOT_BITS-1:0] rx;
  logic signed [ROOT_BITS-1:0] ry;
  qrs_out_t                    out_d;
  qrs_out_t                    out_q;

  assign rx = s5_rx_q[ROOT_BITS-1:0];
  assign ry = s5_ry_q[ROOT_BITS-1:0];

  always_comb begin
    out_d = '0;
    if (s5_err_q) begin
      out_d.lead_zero_error = 1'b1;
    end else if (s5_cplx_q) begin
      // conjugate pair, shared real part
      out_d.first_real    = rx;
      out_d.second_real   = rx;
      out_d.first_imag    = ry;
      out_d.second_imag   = -ry;
      out_d.roots_complex = 1'b1;
    end else begin
      out_d.first_real  = rx;
      out_d.second_real = ry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_item_o = out_q;

endmodule

### rtl/qrs_checker.sv
`include "quadratic_root_solver_macros.svh"

module qrs_checker
  import qrs_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input qrs_in_t  in_item_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input qrs_out_t out_item_o
);

  // a held result keeps its payload
  `QRS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "output item changed while stalled")

  // a waiting input item keeps its payload
  `QRS_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o, in_valid_i && $stable(in_item_i), "input item changed while waiting")

  // an empty output register never blocks the input
  `QRS_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o, "input refused with output empty")

  // lead-zero result carries nothing else
  `QRS_ASSERT_IMP(a_lead_zero, clk_i, rst_ni, out_valid_o && out_item_o.lead_zero_error, out_item_o.first_real == '0 && out_item_o.first_imag == '0 && out_item_o.second_real == '0 && out_item_o.second_imag == '0 && !out_item_o.roots_complex, "lead-zero item has nonzero fields")

  // complex roots form a conjugate pair, real roots have no imaginary part
  `QRS_ASSERT_IMP(a_imag_shape, clk_i, rst_ni, out_valid_o, out_item_o.roots_complex ? (out_item_o.first_real == out_item_o.second_real && ROOT_BITS'(out_item_o.first_imag + out_item_o.second_imag) == '0) : (out_item_o.first_imag == '0 && out_item_o.second_imag == '0), "imaginary parts do not match root kind")

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### verif/quadratic_root_solver_test.sv
module quadratic_root_solver_test;
  import qrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no item moving on either side before the run is declared hung
  localparam int unsigned HANG_LIMIT = 5000;
  // pipeline depth given for the default fraction width, plus some margin
  localparam int unsigned DRAIN_CYCLES = 90;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  qrs_in_t  in_item_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  qrs_out_t out_item_o;

  // coefficient sets waiting to be sent, and root sets waiting to come back
  qrs_in_t  coef_pending[$];
  qrs_out_t roots_expected[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned hang_count = 0;

  quadratic_root_solver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // floor(sqrt(d * 2^(2*frac))), one result bit per step over a wide radicand
  function automatic longint fixed_root(longint unsigned d);
    logic [127:0] radicand;
    logic [127:0] rem;
    logic [127:0] trial;
    logic [127:0] acc;
    radicand = 128'(d) << (2 * FRAC_BITS_DEF);
    rem = '0;
    acc = '0;
    for (int p = 63; p >= 0; p--) begin
      rem = (rem << 2) | ((radicand >> (2 * p)) & 128'd3);
      trial = (acc << 2) | 128'd1;
      acc = acc << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        acc = acc | 128'd1;
      end
    end
    return longint'(acc[63:0]);
  endfunction

  // expected root set for one coefficient set
  function automatic qrs_out_t roots_of(qrs_in_t coef);
    qrs_out_t res;
    longint a, b, c, den, nb, delta, s, re1, re2, im1;
    res = '0;
    a = coef.coef_a;
    b = coef.coef_b;
    c = coef.coef_c;
    if (a == 0) begin
      // degenerate: only the flag is set
      res.lead_zero_error = 1'b1;
      return res;
    end
    den = 2 * a;
    nb = -(b * (64'sd1 <<< FRAC_BITS_DEF));
    delta = b * b - 4 * a * c;
    im1 = 0;
    if (delta >= 0) begin
      s = fixed_root(longint'(delta));
      re1 = (nb + s) / den;
      re2 = (nb - s) / den;
    end else begin
      // conjugate pair, imaginary sign follows the sign of a
      s = fixed_root(longint'(-delta));
      re1 = nb / den;
      re2 = re1;
      im1 = s / den;
      res.roots_complex = 1'b1;
    end
    res.first_real  = re1[ROOT_BITS-1:0];
    res.first_imag  = im1[ROOT_BITS-1:0];
    res.second_real = re2[ROOT_BITS-1:0];
    res.second_imag = ROOT_BITS'(-im1);
    return res;
  endfunction

  // driver: valid holds until taken, gaps drawn per phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        roots_expected.push_back(roots_of(in_item_i));
      end
      if (!in_valid_i || in_ready_o) begin
        if (coef_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_item_i  <= coef_pending.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each taken root set with the oldest expected one
  always @(posedge clk_i or negedge rst_ni) begin
    qrs_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      if (out_valid_o && out_ready_i) begin
        if (roots_expected.size() == 0) begin
          $error("unexpected root item: first_real %0d", $signed(out_item_o.first_real));
          mismatch_count++;
        end else begin
          want = roots_expected.pop_front();
          if (out_item_o.first_real !== want.first_real) begin
            $error("first_real exp %0d got %0d", $signed(want.first_real),
                   $signed(out_item_o.first_real));
            mismatch_count++;
          end
          if (out_item_o.first_imag !== want.first_imag) begin
            $error("first_imag exp %0d got %0d", $signed(want.first_imag),
                   $signed(out_item_o.first_imag));
            mismatch_count++;
          end
          if (out_item_o.second_real !== want.second_real) begin
            $error("second_real exp %0d got %0d", $signed(want.second_real),
                   $signed(out_item_o.second_real));
            mismatch_count++;
          end
          if (out_item_o.second_imag !== want.second_imag) begin
            $error("second_imag exp %0d got %0d", $signed(want.second_imag),
                   $signed(out_item_o.second_imag));
            mismatch_count++;
          end
          if (out_item_o.roots_complex !== want.roots_complex) begin
            $error("roots_complex exp %0b got %0b", want.roots_complex,
                   out_item_o.roots_complex);
            mismatch_count++;
          end
          if (out_item_o.lead_zero_error !== want.lead_zero_error) begin
            $error("lead_zero_error exp %0b got %0b", want.lead_zero_error,
                   out_item_o.lead_zero_error);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog: no item moving on either side for too long means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        hang_count <= 0;
      end else if (hang_count >= HANG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        hang_count <= hang_count + 1;
      end
    end
  end

  task automatic add_coef(int a, int b, int c);
    qrs_in_t it;
    it.coef_a = a[COEF_BITS-1:0];
    it.coef_b = b[COEF_BITS-1:0];
    it.coef_c = c[COEF_BITS-1:0];
    coef_pending.push_back(it);
  endtask

  // random coefficient sets: full range, small values, double roots, zero lead, small a, small b
  task automatic add_random(int unsigned count);
    int k, m;
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_coef($urandom, $urandom, $urandom);
        4, 5: add_coef(int'($urandom_range(40)) - 20, int'($urandom_range(40)) - 20,
                       int'($urandom_range(40)) - 20);
        6: begin
          // double root: b*b == 4*a*c
          k = int'($urandom_range(20)) - 10;
          m = int'($urandom_range(20)) - 10;
          if (k == 0) k = 1;
          add_coef(k, 2 * k * m, k * m * m);
        end
        7: add_coef(0, $urandom, $urandom);
        8: add_coef(int'($urandom_range(6)) - 3, $urandom, $urandom);
        default: add_coef($urandom, int'($urandom_range(8)) - 4, $urandom);
      endcase
    end
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct,
                           int unsigned count);
    send_idle_pct  <= idle_pct;
    recv_stall_pct <= stall_pct;
    add_random(count);
    while (coef_pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero lead, double root, conjugate pairs both signs of a, extremes
    add_coef(0, 5, 3);
    add_coef(0, -32768, 32767);
    add_coef(1, 2, 1);
    add_coef(1, 0, 1);
    add_coef(-1, 0, 1);
    add_coef(-1, 0, -1);
    add_coef(1, -3, 2);
    add_coef(32767, 32767, 32767);
    add_coef(-32768, -32768, -32768);
    add_coef(-32768, 32767, -32768);
    add_coef(32767, -32768, -32768);
    add_coef(1, -32768, -32768);
    add_coef(-32768, 0, 32767);
    add_coef(1, 0, 0);
    add_coef(2, 3, -5);
    add_coef(3, 1, 7);
    add_coef(-7, 4, 9);
    add_coef(1, 32767, 0);
    add_coef(-1, -32768, 0);
    add_coef(32767, 0, -32768);

    run_phase(0, 0, 115);
    run_phase(83, 0, 110);
    run_phase(0, 83, 110);
    run_phase(15, 15, 115);

    while (roots_expected.size() != 0 || in_valid_i) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (roots_expected.size() != 0) begin
      $error("%0d root items never arrived", roots_expected.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
